FILE: design/reverse_name_cache_assert.svh
// Assertion macros shared by the reverse name cache RTL.
`ifndef REVERSE_NAME_CACHE_ASSERT_SVH
`define REVERSE_NAME_CACHE_ASSERT_SVH

// Condition in the same cycle.
`define RNC_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("reverse_name_cache assertion failed");

// Condition in the following cycle.
`define RNC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("reverse_name_cache assertion failed");

`endif

FILE: design/rnc_pkg.sv
// Types and constants of the reverse name cache.
package rnc_pkg;

	localparam int unsigned ENTRIES_DEF = 2048;
	localparam int unsigned SLOT_W      = 11;
	localparam int unsigned NAME_W      = 32;
	localparam int unsigned ADDR_W      = 64;
	localparam int unsigned S_DATA_W    = 176;
	localparam int unsigned M_DATA_W    = 48;

	typedef enum logic [1:0] {
		STS_EMPTY     = 2'd0,
		STS_RESOLVED  = 2'd1,
		STS_RESOLVING = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		OUT_HIT     = 2'd0,
		OUT_MISS    = 2'd1,
		OUT_NOSPACE = 2'd2,
		OUT_DONE    = 2'd3
	} outcome_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_ALLOC,
		ST_CREAD,
		ST_CCHK,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [NAME_W-1:0] name;
		logic [ADDR_W-1:0] addr_high;
		logic [ADDR_W-1:0] addr_low;
		logic              family;
		status_t           status;
	} entry_t;

	localparam int unsigned ENTRY_W = $bits(entry_t);

endpackage

FILE: design/rnc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module rnc_ram #(
	parameter int unsigned WIDTH = rnc_pkg::ENTRY_W,
	parameter int unsigned DEPTH = rnc_pkg::ENTRIES_DEF
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: design/reverse_name_cache.sv
// Top level of the reverse name cache: control sequencer around the entry memory.
//
// One item is handled at a time. After reset a clearing pass writes every
// entry once before the first transfer is taken. A lookup streams the entry
// memory one entry per cycle: the match scan reads up to filled_count
// entries, and a miss then probes from the round-robin pointer until it
// finds a slot that is not resolving, up to ENTRIES probes. The single read
// port of the entry memory sets the length of a lookup. A result may wait in
// the output register while the block returns to idle and takes the next
// item, but the next result is only moved into that register once it is free
// or being taken.
`include "reverse_name_cache_assert.svh"

module reverse_name_cache #(
	parameter int unsigned ENTRIES = rnc_pkg::ENTRIES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	// addr_family, addr_high, addr_low, done_slot, done_ok, done_name, zero pad
	input  logic [rnc_pkg::S_DATA_W-1:0]  s_axis_tdata,
	// mode
	input  logic                          s_axis_tuser,
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// name_out, slot_out, zero pad
	output logic [rnc_pkg::M_DATA_W-1:0]  m_axis_tdata,
	// outcome
	output logic [1:0]                    m_axis_tuser
);

	localparam int unsigned AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int unsigned CW = $clog2(ENTRIES + 1);
	localparam int unsigned SW = rnc_pkg::SLOT_W;
	localparam int unsigned NW = rnc_pkg::NAME_W;
	localparam int unsigned XW = rnc_pkg::ADDR_W;

	rnc_pkg::state_t state_q, state_d;

	// Input item fields.
	logic          in_mode;
	logic          in_fam;
	logic [XW-1:0] in_hi, in_lo;
	logic [SW-1:0] in_ds;
	logic          in_ok;
	logic [NW-1:0] in_name;

	logic          fam_q;
	logic [XW-1:0] hi_q, lo_q;
	logic [SW-1:0] ds_q;
	logic          ok_q;
	logic [NW-1:0] name_q;

	logic [AW-1:0] next_slot_q;
	logic [CW-1:0] filled_q;
	logic [AW-1:0] clr_q;
	logic [CW-1:0] sidx_q;
	logic [AW-1:0] aidx_q;
	logic [CW-1:0] acnt_q;

	logic [AW-1:0] addr_s1;
	logic [AW-1:0] pcnt_s1;
	logic          vld_s1;

	rnc_pkg::outcome_t res_outcome_q;
	logic [NW-1:0]     res_name_q;
	logic [SW-1:0]     res_slot_q;

	logic              m_valid_q;
	rnc_pkg::outcome_t m_outcome_q;
	logic [NW-1:0]     m_name_q;
	logic [SW-1:0]     m_slot_q;

	// Memory port.
	logic                  mem_we, mem_re;
	logic [AW-1:0]         mem_waddr, mem_raddr;
	rnc_pkg::entry_t       mem_wdata, mem_rdata;

	// Decisions of the current cycle.
	logic s_fire;
	logic ds_in_range;
	logic scan_match, scan_last, scan_hit, scan_to_alloc;
	logic alloc_found, alloc_full;
	logic out_load;
	logic comp_write;

	assign in_mode = s_axis_tuser;
	assign in_fam  = s_axis_tdata[0];
	assign in_hi   = s_axis_tdata[64:1];
	assign in_lo   = s_axis_tdata[128:65];
	assign in_ds   = s_axis_tdata[139:129];
	assign in_ok   = s_axis_tdata[140];
	assign in_name = s_axis_tdata[172:141];

	assign s_fire      = s_axis_tvalid && s_axis_tready;
	assign ds_in_range = 32'(ds_q) < 32'(ENTRIES);

	assign scan_match = vld_s1 && (mem_rdata.family == fam_q) &&
		(mem_rdata.addr_high == hi_q) && (mem_rdata.addr_low == lo_q);
	assign scan_last  = vld_s1 && ((CW'(addr_s1) + CW'(1)) == filled_q);
	assign scan_hit   = scan_match && (mem_rdata.status == rnc_pkg::STS_RESOLVED);
	assign scan_to_alloc = (scan_match && !scan_hit) || (!scan_match && scan_last);

	assign alloc_found = vld_s1 && (mem_rdata.status != rnc_pkg::STS_RESOLVING);
	assign alloc_full  = vld_s1 && !alloc_found && (pcnt_s1 == AW'(ENTRIES - 1));

	assign comp_write = (mem_rdata.status == rnc_pkg::STS_RESOLVING);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			rnc_pkg::ST_CLEAR: begin
				if (clr_q == AW'(ENTRIES - 1)) begin
					state_d = rnc_pkg::ST_IDLE;
				end
			end
			rnc_pkg::ST_IDLE: begin
				if (s_fire) begin
					if (in_mode) begin
						state_d = rnc_pkg::ST_CREAD;
					end else if (filled_q == '0) begin
						state_d = rnc_pkg::ST_ALLOC;
					end else begin
						state_d = rnc_pkg::ST_SCAN;
					end
				end
			end
			rnc_pkg::ST_SCAN: begin
				if (scan_hit) begin
					state_d = rnc_pkg::ST_DONE;
				end else if (scan_to_alloc) begin
					state_d = rnc_pkg::ST_ALLOC;
				end
			end
			rnc_pkg::ST_ALLOC: begin
				if (alloc_found || alloc_full) begin
					state_d = rnc_pkg::ST_DONE;
				end
			end
			rnc_pkg::ST_CREAD: begin
				state_d = ds_in_range ? rnc_pkg::ST_CCHK : rnc_pkg::ST_DONE;
			end
			rnc_pkg::ST_CCHK: begin
				state_d = rnc_pkg::ST_DONE;
			end
			rnc_pkg::ST_DONE: begin
				if (!m_valid_q || m_axis_tready) begin
					state_d = rnc_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = rnc_pkg::ST_IDLE;
			end
		endcase
	end

	// Outputs of the sequencer: memory port and handshake.
	always_comb begin
		s_axis_tready = 1'b0;
		mem_re        = 1'b0;
		mem_raddr     = '0;
		mem_we        = 1'b0;
		mem_waddr     = '0;
		mem_wdata     = '0;
		out_load      = 1'b0;
		unique case (state_q)
			rnc_pkg::ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
			end
			rnc_pkg::ST_IDLE: begin
				s_axis_tready = 1'b1;
			end
			rnc_pkg::ST_SCAN: begin
				mem_re    = (sidx_q < filled_q);
				mem_raddr = sidx_q[AW-1:0];
			end
			rnc_pkg::ST_ALLOC: begin
				mem_re    = (acnt_q < CW'(ENTRIES));
				mem_raddr = aidx_q;
				if (alloc_found) begin
					mem_we              = 1'b1;
					mem_waddr           = addr_s1;
					mem_wdata.name      = mem_rdata.name;
					mem_wdata.addr_high = hi_q;
					mem_wdata.addr_low  = lo_q;
					mem_wdata.family    = fam_q;
					mem_wdata.status    = rnc_pkg::STS_RESOLVING;
				end
			end
			rnc_pkg::ST_CREAD: begin
				mem_re    = ds_in_range;
				mem_raddr = AW'(ds_q);
			end
			rnc_pkg::ST_CCHK: begin
				mem_we           = comp_write;
				mem_waddr        = AW'(ds_q);
				mem_wdata        = mem_rdata;
				mem_wdata.status = rnc_pkg::STS_RESOLVED;
				if (ok_q) begin
					mem_wdata.name = name_q;
				end
			end
			rnc_pkg::ST_DONE: begin
				out_load = !m_valid_q || m_axis_tready;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	rnc_ram #(
		.WIDTH(rnc_pkg::ENTRY_W),
		.DEPTH(ENTRIES)
	) u_entries (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rnc_pkg::ST_CLEAR;
			next_slot_q <= '0;
			filled_q    <= '0;
			clr_q       <= '0;
			vld_s1      <= 1'b0;
			m_valid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			vld_s1  <= mem_re && (state_d == state_q);
			if (state_q == rnc_pkg::ST_CLEAR) begin
				clr_q <= clr_q + AW'(1);
			end
			if (state_q == rnc_pkg::ST_ALLOC && alloc_found) begin
				if (filled_q < CW'(ENTRIES)) begin
					filled_q <= filled_q + CW'(1);
				end
				next_slot_q <= (addr_s1 == AW'(ENTRIES - 1)) ? '0 : addr_s1 + AW'(1);
			end
			if (out_load) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// Item, scan pointers, read pipeline and result payload.
	always_ff @(posedge clk) begin
		addr_s1 <= mem_raddr;
		pcnt_s1 <= acnt_q[AW-1:0];
		if (s_fire) begin
			fam_q   <= in_fam;
			hi_q    <= in_fam ? in_hi : '0;
			lo_q    <= in_fam ? in_lo : {32'd0, in_lo[31:0]};
			ds_q    <= in_ds;
			ok_q    <= in_ok;
			name_q  <= in_name;
			sidx_q  <= '0;
			aidx_q  <= next_slot_q;
			acnt_q  <= '0;
			res_outcome_q <= rnc_pkg::OUT_DONE;
			res_name_q    <= '0;
			res_slot_q    <= in_ds;
		end
		if (state_q == rnc_pkg::ST_SCAN && mem_re) begin
			sidx_q <= sidx_q + CW'(1);
		end
		if (state_q == rnc_pkg::ST_SCAN && scan_hit) begin
			res_outcome_q <= rnc_pkg::OUT_HIT;
			res_name_q    <= mem_rdata.name;
			res_slot_q    <= SW'(addr_s1);
		end
		if (state_q == rnc_pkg::ST_ALLOC) begin
			if (mem_re) begin
				aidx_q <= (aidx_q == AW'(ENTRIES - 1)) ? '0 : aidx_q + AW'(1);
				acnt_q <= acnt_q + CW'(1);
			end
			if (alloc_found) begin
				res_outcome_q <= rnc_pkg::OUT_MISS;
				res_name_q    <= '0;
				res_slot_q    <= SW'(addr_s1);
			end else if (alloc_full) begin
				res_outcome_q <= rnc_pkg::OUT_NOSPACE;
				res_name_q    <= '0;
				res_slot_q    <= '0;
			end
		end
		if (out_load) begin
			m_outcome_q <= res_outcome_q;
			m_name_q    <= res_name_q;
			m_slot_q    <= res_slot_q;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tuser  = m_outcome_q;
	assign m_axis_tdata  = {5'd0, m_slot_q, m_name_q};

	`RNC_ASSERT_NOW(a_no_write_in_scan, state_q == rnc_pkg::ST_SCAN, !mem_we)
	`RNC_ASSERT_NOW(a_fill_bounded, 1'b1, filled_q <= CW'(ENTRIES))
	`RNC_ASSERT_NEXT(a_one_item, s_fire, !s_axis_tready)

endmodule

FILE: bench/reverse_name_cache_test.sv
// Testbench for the reverse name cache: lookups and completions checked against a predictor.
module reverse_name_cache_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned NSLOT = rnc_pkg::ENTRIES_DEF;
	localparam int unsigned CYCLE_LIMIT = 6000000;

	typedef logic [rnc_pkg::SLOT_W-1:0] slot_t;

	typedef struct {
		rnc_pkg::outcome_t          outcome;
		logic [rnc_pkg::NAME_W-1:0] name;
		slot_t                      slot;
	} result_t;

	logic                         clk;
	logic                         arst_n;
	logic                         s_axis_tvalid;
	logic                         s_axis_tready;
	logic [rnc_pkg::S_DATA_W-1:0] s_axis_tdata;
	logic                         s_axis_tuser;
	logic                         m_axis_tvalid;
	logic                         m_axis_tready;
	logic [rnc_pkg::M_DATA_W-1:0] m_axis_tdata;
	logic [1:0]                   m_axis_tuser;

	reverse_name_cache u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
	);

	// Shadow copy of the cache contents.
	logic [rnc_pkg::ADDR_W-1:0] cache_hi [NSLOT];
	logic [rnc_pkg::ADDR_W-1:0] cache_lo [NSLOT];
	logic                       cache_fam [NSLOT];
	logic [rnc_pkg::NAME_W-1:0] cache_name [NSLOT];
	rnc_pkg::status_t           cache_sts [NSLOT];
	int unsigned                rr_ptr;
	int unsigned                fill_cnt;
	int unsigned                resolving_q [$];

	result_t     pending_results [$];
	int unsigned mismatch_cnt;
	int unsigned cycle_cnt;
	int unsigned rx_hold;
	int unsigned rx_gap;
	bit          no_gaps;

	initial begin
		clk = 1'b0;
		forever begin
			#10 clk = 1'b1;
			#10 clk = 1'b0;
		end
	end

	function automatic int unsigned pick_gap();
		if (no_gaps)
			return 0;
		if ($urandom_range(0, 9) < 8)
			return $urandom_range(0, 2);
		return $urandom_range(3, 40);
	endfunction

	function automatic result_t cache_predict(input logic mode, input logic fam,
			input logic [rnc_pkg::ADDR_W-1:0] hi, input logic [rnc_pkg::ADDR_W-1:0] lo,
			input slot_t dslot, input logic ok, input logic [rnc_pkg::NAME_W-1:0] nm);
		result_t r;
		int unsigned i;
		int unsigned k;
		int unsigned s;
		r.name = '0;
		r.slot = '0;
		if (mode) begin
			if (cache_sts[dslot] == rnc_pkg::STS_RESOLVING) begin
				if (ok)
					cache_name[dslot] = nm;
				cache_sts[dslot] = rnc_pkg::STS_RESOLVED;
			end
			r.outcome = rnc_pkg::OUT_DONE;
			r.slot = dslot;
			return r;
		end
		// IPv4 keeps only the low 32 address bits.
		if (!fam) begin
			hi = '0;
			lo = {32'd0, lo[31:0]};
		end
		for (i = 0; i < fill_cnt; i++) begin
			if (cache_fam[i] == fam && cache_hi[i] == hi && cache_lo[i] == lo) begin
				if (cache_sts[i] == rnc_pkg::STS_RESOLVED) begin
					r.outcome = rnc_pkg::OUT_HIT;
					r.name = cache_name[i];
					r.slot = i[rnc_pkg::SLOT_W-1:0];
					return r;
				end
				break;
			end
		end
		s = rr_ptr;
		for (k = 0; k < NSLOT; k++) begin
			if (cache_sts[s] != rnc_pkg::STS_RESOLVING)
				break;
			s = (s + 1) % NSLOT;
		end
		if (k == NSLOT) begin
			r.outcome = rnc_pkg::OUT_NOSPACE;
			return r;
		end
		cache_fam[s] = fam;
		cache_hi[s] = hi;
		cache_lo[s] = lo;
		cache_sts[s] = rnc_pkg::STS_RESOLVING;
		resolving_q.push_back(s);
		if (fill_cnt < NSLOT)
			fill_cnt++;
		rr_ptr = (s + 1) % NSLOT;
		r.outcome = rnc_pkg::OUT_MISS;
		r.slot = s[rnc_pkg::SLOT_W-1:0];
		return r;
	endfunction

	// Called at a falling edge; returns at a falling edge after the transfer and its gap.
	task automatic send_item(input logic mode, input logic fam,
			input logic [rnc_pkg::ADDR_W-1:0] hi, input logic [rnc_pkg::ADDR_W-1:0] lo,
			input slot_t dslot, input logic ok, input logic [rnc_pkg::NAME_W-1:0] nm);
		int unsigned gap;
		s_axis_tdata <= {3'd0, nm, ok, dslot, lo, hi, fam};
		s_axis_tuser <= mode;
		s_axis_tvalid <= 1'b1;
		do
			@(posedge clk);
		while (!s_axis_tready);
		pending_results.push_back(cache_predict(mode, fam, hi, lo, dslot, ok, nm));
		@(negedge clk);
		gap = pick_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	task automatic lookup(input logic fam, input logic [rnc_pkg::ADDR_W-1:0] hi,
			input logic [rnc_pkg::ADDR_W-1:0] lo);
		send_item(1'b0, fam, hi, lo, slot_t'($urandom), 1'($urandom), $urandom);
	endtask

	task automatic complete(input slot_t dslot, input logic ok,
			input logic [rnc_pkg::NAME_W-1:0] nm);
		send_item(1'b1, 1'($urandom), {$urandom, $urandom}, {$urandom, $urandom},
			dslot, ok, nm);
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
	endtask

	task automatic test_directed();
		no_gaps = 1'b0;
		// IPv4 extremes with garbage in the ignored upper bits.
		lookup(1'b0, '1, 64'hFFFF_FFFF_0000_0000);
		lookup(1'b0, 64'h1234_5678_9ABC_DEF0, 64'hA5A5_A5A5_FFFF_FFFF);
		lookup(1'b1, '0, '0);
		lookup(1'b1, '1, '1);
		complete(11'd0, 1'b1, 32'hFFFF_FFFF);
		complete(11'd1, 1'b1, 32'h0000_0001);
		complete(11'd2, 1'b0, 32'hDEAD_BEEF);
		complete(11'd3, 1'b1, 32'h8000_0000);
		// Hits; the IPv4 lookups differ from the stored ones only in ignored bits.
		lookup(1'b0, '0, 64'h0);
		lookup(1'b0, 64'h77, 64'h5555_5555_FFFF_FFFF);
		lookup(1'b1, '0, '0);
		lookup(1'b1, '1, '1);
		// Completions on the empty top slot and on a resolved slot.
		complete(11'd2047, 1'b1, 32'h1111_1111);
		complete(11'd0, 1'b1, 32'h2222_2222);
		lookup(1'b0, '0, 64'hFFFF_FFFF);
		// The first match is still resolving, so a later resolved copy is not seen.
		lookup(1'b1, 64'hC0DE, 64'hF00D);
		lookup(1'b1, 64'hC0DE, 64'hF00D);
		complete(11'd5, 1'b1, 32'h0BAD_CAFE);
		lookup(1'b1, 64'hC0DE, 64'hF00D);
		complete(11'd4, 1'b0, 32'h0);
		lookup(1'b1, 64'hC0DE, 64'hF00D);
		drain();
	endtask

	task automatic test_random(input int unsigned count);
		logic [rnc_pkg::ADDR_W-1:0] pool_hi [16];
		logic [rnc_pkg::ADDR_W-1:0] pool_lo [16];
		logic                       pool_fam [16];
		int unsigned n;
		int unsigned p;
		int unsigned idx;
		for (p = 0; p < 16; p++) begin
			pool_fam[p] = 1'($urandom);
			pool_hi[p] = {$urandom, $urandom};
			pool_lo[p] = {$urandom, $urandom};
		end
		for (n = 0; n < count; n++) begin
			if (n % 60 == 0)
				no_gaps = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 9) < 4) begin
				if (resolving_q.size() != 0 && $urandom_range(0, 9) < 8) begin
					idx = $urandom_range(0, resolving_q.size() - 1);
					p = resolving_q[idx];
					resolving_q.delete(idx);
					complete(p[rnc_pkg::SLOT_W-1:0], $urandom_range(0, 4) != 0, $urandom);
				end else begin
					complete(slot_t'($urandom), 1'($urandom), $urandom);
				end
			end else if ($urandom_range(0, 9) < 7) begin
				p = $urandom_range(0, 15);
				// Upper bits of an IPv4 pool address change but must not matter.
				lookup(pool_fam[p], pool_fam[p] ? pool_hi[p] : {$urandom, $urandom},
					pool_fam[p] ? pool_lo[p] : {$urandom, pool_lo[p][31:0]});
			end else begin
				lookup(1'($urandom), {$urandom, $urandom}, {$urandom, $urandom});
			end
		end
		no_gaps = 1'b0;
		drain();
	endtask

	task automatic test_backpressure();
		int unsigned n;
		rx_hold = 400;
		for (n = 0; n < 20; n++) begin
			if (n % 3 == 0)
				complete(slot_t'($urandom), 1'($urandom), $urandom);
			else
				lookup(1'($urandom), {$urandom, $urandom}, {$urandom, $urandom});
		end
		drain();
	endtask

	// Receiver: random stalls plus a long hold-off when one is requested.
	always @(negedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else if (rx_hold > 0) begin
			m_axis_tready <= 1'b0;
			rx_hold <= rx_hold - 1;
		end else if (no_gaps) begin
			m_axis_tready <= 1'b1;
		end else if (rx_gap > 0) begin
			m_axis_tready <= 1'b0;
			rx_gap <= rx_gap - 1;
		end else begin
			m_axis_tready <= 1'b1;
			if ($urandom_range(0, 3) == 0)
				rx_gap <= pick_gap();
		end
	end

	always @(posedge clk) begin
		result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_results.size() == 0) begin
				mismatch_cnt++;
				if (mismatch_cnt <= 10)
					$display("Unexpected result transfer: outcome %0d name %h slot %0d",
						m_axis_tuser, m_axis_tdata[31:0], m_axis_tdata[42:32]);
			end else begin
				want = pending_results.pop_front();
				if (m_axis_tuser !== want.outcome || m_axis_tdata[31:0] !== want.name ||
						m_axis_tdata[42:32] !== want.slot || m_axis_tdata[47:43] !== 5'd0) begin
					mismatch_cnt++;
					if (mismatch_cnt <= 10)
						$display("Mismatch: expected outcome %0d name %h slot %0d, ",
							want.outcome, want.name, want.slot,
							"got outcome %0d name %h slot %0d pad %b", m_axis_tuser,
							m_axis_tdata[31:0], m_axis_tdata[42:32], m_axis_tdata[47:43]);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		int unsigned s;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = 1'b0;
		m_axis_tready = 1'b0;
		mismatch_cnt = 0;
		cycle_cnt = 0;
		rx_hold = 0;
		rx_gap = 0;
		no_gaps = 1'b0;
		rr_ptr = 0;
		fill_cnt = 0;
		for (s = 0; s < NSLOT; s++) begin
			cache_hi[s] = '0;
			cache_lo[s] = '0;
			cache_fam[s] = 1'b0;
			cache_name[s] = '0;
			cache_sts[s] = rnc_pkg::STS_EMPTY;
		end
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_random(250);
		test_backpressure();
		repeat (50) @(posedge clk);
		if (mismatch_cnt == 0 && pending_results.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule
